>>> rtl/ssc_pkg.sv
// shared types and constants for the signed subset sum checker
// used by ssc_shift_unit and signed_subset_sum_check_top; no dependencies
package ssc_pkg;

  localparam int SPAN    = 1023;
  localparam int VEC_LEN = 2 * SPAN + 1;
  localparam int PAIRS   = 6;
  localparam int MAG_W   = 2 * PAIRS;
  localparam int VALUE_W = 11;

  typedef logic [VEC_LEN-1:0] vec_t;
  typedef logic [MAG_W-1:0]   mag_t;
  typedef logic [2:0]         step_t;

  localparam vec_t  VEC_ZERO_ONLY = vec_t'(1) << SPAN;
  localparam step_t STEP_LAST     = step_t'(PAIRS - 1);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_DOWN = 3'b010,
    ST_UP   = 3'b100
  } state_t;

  typedef struct packed {
    logic       up;
    step_t      pair;
    logic [1:0] bits;
  } shift_ctl_t;

endpackage

>>> rtl/ssc_shift_unit.sv
// shared shift unit: two conditional power-of-two shift stages per cycle
// depends on ssc_pkg
module ssc_shift_unit (
  input  ssc_pkg::vec_t       din,
  input  ssc_pkg::shift_ctl_t ctl,
  output ssc_pkg::vec_t       dout
);

  ssc_pkg::vec_t lo_stage;
  ssc_pkg::vec_t hi_stage;

  always_comb begin
    lo_stage = din;
    for (int j = 0; j < ssc_pkg::PAIRS; j++) begin
      if (ctl.pair == ssc_pkg::step_t'(j) && ctl.bits[0]) begin
        lo_stage = ctl.up ? (din << (1 << (2 * j))) : (din >> (1 << (2 * j)));
      end
    end
    hi_stage = lo_stage;
    for (int j = 0; j < ssc_pkg::PAIRS; j++) begin
      if (ctl.pair == ssc_pkg::step_t'(j) && ctl.bits[1]) begin
        hi_stage = ctl.up ? (lo_stage << (2 << (2 * j))) : (lo_stage >> (2 << (2 * j)));
      end
    end
  end

  assign dout = hi_stage;

endmodule

>>> rtl/signed_subset_sum_check_top.sv
// signed subset sum checker: reachable-sum vector, sequencer, output register
// depends on ssc_pkg and ssc_shift_unit
//
//  channel  dir  fields (tdata low bit up)      notes
//  s_*      in   value[10:0], pad; tlast=last   one word per element
//  m_*      out  answer_yes[0], pad             one word per case
//
// each element is accepted while idle, then takes six shift-down steps and six
// shift-up steps through the shared shift unit (two magnitude bits a step)
// s_tready is high only while idle; the answer appears the cycle after the
// last up step and the block is ready again at once
// an answer not yet taken holds the final up step of the next case's end
// reset is synchronous and leaves the vector holding only the zero sum
module signed_subset_sum_check_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // value[10:0], zeros
  input  logic        s_tlast,   // last
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata    // answer_yes[0], zeros
);

  ssc_pkg::state_t     state;
  ssc_pkg::vec_t       vec;
  ssc_pkg::vec_t       work;
  ssc_pkg::vec_t       shifted;
  ssc_pkg::vec_t       merged;
  ssc_pkg::mag_t       mag;
  ssc_pkg::mag_t       mag_next;
  ssc_pkg::step_t      step;
  ssc_pkg::shift_ctl_t ctl;
  logic                last_r;
  logic                found;
  logic                answer;
  logic                final_step;
  logic                hold;
  logic                emit;
  logic [ssc_pkg::VALUE_W:0] value_ext;

  assign value_ext = {s_tdata[ssc_pkg::VALUE_W-1], s_tdata[ssc_pkg::VALUE_W-1:0]};

  always_comb begin
    if (s_tdata[ssc_pkg::VALUE_W-1]) begin
      mag_next = ssc_pkg::mag_t'(0) - ssc_pkg::mag_t'(value_ext);
    end else begin
      mag_next = ssc_pkg::mag_t'(value_ext);
    end
  end

  always_comb begin
    ctl.up   = (state == ssc_pkg::ST_UP);
    ctl.pair = step;
    ctl.bits = mag[{step, 1'b0} +: 2];
  end

  ssc_shift_unit u_shift (
    .din  (work),
    .ctl  (ctl),
    .dout (shifted)
  );

  assign merged     = vec | shifted;
  assign final_step = (step == ssc_pkg::STEP_LAST);
  assign hold       = (state == ssc_pkg::ST_UP) && final_step && last_r
                      && m_tvalid && !m_tready;
  assign emit       = (state == ssc_pkg::ST_UP) && final_step && last_r && !hold;
  assign s_tready   = (state == ssc_pkg::ST_IDLE);
  assign m_tdata    = {7'd0, answer};

  // vector stays symmetric, so bit SPAN of the down-shifted copy tests +m and -m
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ssc_pkg::ST_IDLE;
      vec      <= ssc_pkg::VEC_ZERO_ONLY;
      found    <= 1'b0;
      step     <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (emit) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ssc_pkg::ST_IDLE: begin
          if (s_tvalid) begin
            mag    <= mag_next;
            last_r <= s_tlast;
            work   <= vec;
            step   <= '0;
            state  <= ssc_pkg::ST_DOWN;
          end
        end
        ssc_pkg::ST_DOWN: begin
          if (final_step) begin
            vec   <= merged;
            found <= found | shifted[ssc_pkg::SPAN];
            work  <= merged;
            step  <= '0;
            state <= ssc_pkg::ST_UP;
          end else begin
            work <= shifted;
            step <= step + 3'd1;
          end
        end
        ssc_pkg::ST_UP: begin
          if (!final_step) begin
            work <= shifted;
            step <= step + 3'd1;
          end else if (!hold) begin
            state <= ssc_pkg::ST_IDLE;
            if (last_r) begin
              answer   <= found;
              vec      <= ssc_pkg::VEC_ZERO_ONLY;
              found    <= 1'b0;
            end else begin
              vec <= merged;
            end
          end
        end
        default: begin
          state <= ssc_pkg::ST_IDLE;
        end
      endcase
    end
  end

endmodule

>>> dv/tb_signed_subset_sum_check_top.sv
// testbench for signed_subset_sum_check_top: directed then random cases of signed
// words, answers checked against a reachable-sum predictor held in a scoreboard class
// depends on ssc_pkg and the rtl of signed_subset_sum_check_top
module tb_signed_subset_sum_check_top;
  timeunit 1ns;
  timeprecision 1ps;

  import ssc_pkg::*;

  localparam int WORDS_WANTED = 800;
  localparam int STALL_LIMIT  = 3000;
  localparam int END_CYCLES   = 40;
  localparam int REPORT_MAX   = 10;

  class subset_sum_scoreboard;
    vec_t sums;
    bit   found;
    bit   pending_answers[$];
    int   mismatches;

    function new();
      mismatches = 0;
      clear_case();
    endfunction

    function void clear_case();
      sums  = VEC_ZERO_ONLY;
      found = 1'b0;
    endfunction

    function void absorb_value(logic [VALUE_W-1:0] raw, logic last_word);
      int mag;
      mag = raw[VALUE_W-1] ? (1 << VALUE_W) - int'(raw) : int'(raw);
      if (mag <= SPAN) begin
        if (sums[SPAN + mag] || sums[SPAN - mag]) found = 1'b1;
      end
      if (mag > 0 && mag < VEC_LEN) begin
        sums = sums | (sums >> mag);
        sums = sums | (sums << mag);
      end
      if (last_word) begin
        pending_answers = {pending_answers, found};
        clear_case();
      end
    endfunction

    function void compare_answer(logic got);
      bit want;
      if (pending_answers.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("answer %0b arrived with none pending", got);
      end else begin
        want = pending_answers.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= REPORT_MAX)
            $display("answer_yes mismatch: expected %0b, actual %0b", want, got);
        end
      end
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [15:0] s_tdata;
  logic        s_tlast;
  logic        m_tvalid;
  logic        m_tready;
  logic [7:0]  m_tdata;

  subset_sum_scoreboard sb;
  int words_sent;
  int answers_taken;
  int stall_cycles;

  signed_subset_sum_check_top dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) sb.absorb_value(s_tdata[VALUE_W-1:0], s_tlast);
      if (m_tvalid && m_tready) sb.compare_answer(m_tdata[0]);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
        stall_cycles <= 0;
      end else begin
        stall_cycles <= stall_cycles + 1;
        if (stall_cycles + 1 >= STALL_LIMIT) begin
          $display("status: fail");
          $finish;
        end
      end
    end
  end

  task automatic send_word(input logic [VALUE_W-1:0] v, input logic lst);
    int gap;
    gap = (((words_sent / 50) % 5) == 4) ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      s_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tdata  = {5'b0, v};
    s_tlast  = lst;
    do @(posedge clk); while (!s_tready);
    words_sent++;
    @(negedge clk);
  endtask

  task automatic send_case(input int vals[$]);
    foreach (vals[i]) send_word(VALUE_W'(vals[i]), i == vals.size() - 1);
  endtask

  task automatic drain_answers();
    s_tvalid = 1'b0;
    while (sb.pending_answers.size() != 0) @(negedge clk);
  endtask

  // random signed word with magnitude up to mag_max
  function automatic int signed_word(int mag_max);
    int mag;
    mag = $urandom_range(0, mag_max);
    return $urandom_range(0, 1) ? -mag : mag;
  endfunction

  task automatic send_random_case();
    int vals[$];
    int len;
    int kind;
    int a;
    int b;
    len  = $urandom_range(1, 8);
    kind = $urandom_range(0, 9);
    if (kind >= 8) begin
      a = signed_word(500);
      b = signed_word(500);
      vals = {vals, a};
      repeat ($urandom_range(0, 3)) vals = {vals, signed_word(30)};
      vals = {vals, b};
      vals = {vals, ($urandom_range(0, 1) ? a + b : a - b)};
    end else begin
      repeat (len) begin
        if (kind <= 5) vals = {vals, signed_word(30)};
        else vals = {vals, int'($signed(VALUE_W'($urandom_range(0, 2047))))};
      end
    end
    send_case(vals);
  endtask

  initial begin
    m_tready = 1'b0;
    wait (rst === 1'b0);
    @(negedge clk);
    forever begin
      int gap;
      gap = (((answers_taken / 16) % 4) == 3) ? 0 : $urandom_range(0, 5);
      m_tready = 1'b0;
      repeat (gap) @(negedge clk);
      m_tready = 1'b1;
      do @(posedge clk); while (!m_tvalid);
      answers_taken++;
      @(negedge clk);
    end
  end

  initial begin
    sb            = new();
    words_sent    = 0;
    answers_taken = 0;
    stall_cycles  = 0;
    rst      = 1'b1;
    s_tvalid = 1'b0;
    s_tdata  = '0;
    s_tlast  = 1'b0;
    repeat (6) @(negedge clk);
    rst = 1'b0;

    // zero magnitude, lone value, signed sum, most negative word, edge overflow
    send_case('{0});
    send_case('{5});
    send_case('{3, -4, 7});
    send_case('{-1024});
    send_case('{1023, -1023});
    send_case('{1000, -900, 100});
    send_case('{600, 700, -1023});
    send_case('{-1024, 0});
    drain_answers();

    while (words_sent < WORDS_WANTED) begin
      send_random_case();
      if ($urandom_range(0, 39) == 0) drain_answers();
    end
    s_tvalid = 1'b0;
    drain_answers();
    repeat (END_CYCLES) @(posedge clk);

    if (sb.mismatches == 0 && sb.pending_answers.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/ssc_pkg.sv
rtl/ssc_shift_unit.sv
rtl/signed_subset_sum_check_top.sv
dv/tb_signed_subset_sum_check_top.sv
